// File: rtl/core/indexed_vector_engine_top_assert.svh
// ----------------------------------------------------------------------------
// indexed vector engine assertion macros
// concurrent checks clocked on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef INDEXED_VECTOR_ENGINE_TOP_ASSERT_SVH
`define INDEXED_VECTOR_ENGINE_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define IVE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define IVE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ive_pkg.sv
// ----------------------------------------------------------------------------
// ive_pkg
// shared types and codes of the indexed vector engine
// ----------------------------------------------------------------------------
package ive_pkg;

    localparam int CMD_W    = 3;
    localparam int IDX_W    = 5;
    localparam int VAL_W    = 32;
    localparam int STEPS_W  = 8;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 4;
    localparam int LEN_W    = 5;

    localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd5;
    localparam logic [CMD_W-1:0] CMD_ROTL   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_ROTR   = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISS  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

    // what a cell does with its word this cycle
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_LEFT,
        OP_RIGHT,
        OP_WRAP,
        OP_CLEAR
    } t_cell_op;

endpackage

// File: rtl/core/ive_cell.sv
// ----------------------------------------------------------------------------
// ive_cell
// one storage cell of the chain: holds a word, takes it from a neighbour,
// the load bus or the wrap bus, and flags a match against the search key
// ----------------------------------------------------------------------------
module ive_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ive_pkg::t_cell_op     i_op,
    input  logic [DATA_WIDTH-1:0] i_load,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    input  logic [DATA_WIDTH-1:0] i_wrap,
    input  logic [DATA_WIDTH-1:0] i_key,
    output logic [DATA_WIDTH-1:0] o_word,
    output logic                  o_match
);

    logic [DATA_WIDTH-1:0] r_word;
    logic [DATA_WIDTH-1:0] n_word;
    logic                  r_match;

    always_comb begin
        case (i_op)
            ive_pkg::OP_HOLD:  n_word = r_word;
            ive_pkg::OP_LOAD:  n_word = i_load;
            ive_pkg::OP_LEFT:  n_word = i_left;
            ive_pkg::OP_RIGHT: n_word = i_right;
            ive_pkg::OP_WRAP:  n_word = i_wrap;
            ive_pkg::OP_CLEAR: n_word = '0;
            default:           n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word  <= '0;
            r_match <= 1'b0;
        end else begin
            r_word  <= n_word;
            r_match <= (r_word == i_key);
        end
    end

    assign o_word  = r_word;
    assign o_match = r_match;

endmodule

// File: rtl/core/ive_mod_unit.sv
// ----------------------------------------------------------------------------
// ive_mod_unit
// bit-serial remainder of the rotate distance by the element count,
// one restoring step per cycle
// ----------------------------------------------------------------------------
module ive_mod_unit #(
    parameter int CAPACITY = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [ive_pkg::STEPS_W-1:0]         i_steps,
    input  logic [$clog2(CAPACITY+1)-1:0]       i_count,
    output logic                                o_done,
    output logic [$clog2(CAPACITY+1)-1:0]       o_rem
);

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int ITW = $clog2(ive_pkg::STEPS_W);

    logic                        r_busy;
    logic                        r_done;
    logic [ITW-1:0]              r_iter;
    logic [ive_pkg::STEPS_W-1:0] r_shift;
    logic [CW-1:0]               r_rem;
    logic [CW:0]                 w_trial;
    logic [CW:0]                 w_diff;
    logic [CW-1:0]               n_rem;

    always_comb begin
        w_trial = {r_rem, r_shift[ive_pkg::STEPS_W-1]};
        w_diff  = w_trial - {1'b0, i_count};
        // remainder stays below the count, so the top bit drops out
        if (w_trial >= {1'b0, i_count}) begin
            n_rem = w_diff[CW-1:0];
        end else begin
            n_rem = w_trial[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= ITW'(ive_pkg::STEPS_W - 1);
            end else if (r_busy) begin
                r_iter <= r_iter - 1'b1;
                if (r_iter == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_steps;
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= {r_shift[ive_pkg::STEPS_W-2:0], 1'b0};
            r_rem   <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: rtl/core/indexed_vector_engine_top.sv
// ----------------------------------------------------------------------------
// indexed_vector_engine_top
// ordered array of words in a chain of cells with read, write, find, append,
// insert, delete and rotate commands
// ----------------------------------------------------------------------------
// One command is worked on at a time and each gives one result item. Read,
// write, append, insert, delete and rotate left go from the execute state
// straight to the result, as every cell moves or loads its word at once;
// find passes through a find state, the cells registering their match flags
// before the first hit is encoded. Rotate right by steps has the remainder
// unit work out steps mod length, and the chain then moves one place per
// cycle; on an empty array or a zero remainder it finishes without moving.
// A new command is taken once the previous result has entered the output
// register, even while it waits there; a result parked behind a full one holds new commands off.
`include "indexed_vector_engine_top_assert.svh"

module indexed_vector_engine_top #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [ive_pkg::CMD_W-1:0]            i_command,
    input  logic [ive_pkg::IDX_W-1:0]            i_index,
    input  logic signed [ive_pkg::VAL_W-1:0]     i_value,
    input  logic [ive_pkg::STEPS_W-1:0]          i_steps,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [ive_pkg::STATUS_W-1:0]         o_status,
    output logic signed [ive_pkg::VAL_W-1:0]     o_read_value,
    output logic [ive_pkg::POS_W-1:0]            o_position,
    output logic [ive_pkg::LEN_W-1:0]            o_length
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > ive_pkg::IDX_W) ? CW : ive_pkg::IDX_W;
    localparam int DW   = DATA_WIDTH;
    localparam int VW   = ive_pkg::VAL_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_FIND = 6'b000100,
        S_DIV  = 6'b001000,
        S_ROT  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // command held for the duration of its work
    logic [ive_pkg::CMD_W-1:0]   r_command;
    logic [ive_pkg::IDX_W-1:0]   r_index;
    logic [VW-1:0]               r_value;
    logic [ive_pkg::STEPS_W-1:0] r_steps;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_rot;

    logic [ive_pkg::STATUS_W-1:0] r_res_status;
    logic [VW-1:0]                r_res_read;
    logic [ive_pkg::POS_W-1:0]    r_res_pos;
    logic [ive_pkg::LEN_W-1:0]    r_res_len;

    logic                         r_out_valid;
    logic [ive_pkg::STATUS_W-1:0] r_out_status;
    logic [VW-1:0]                r_out_read;
    logic [ive_pkg::POS_W-1:0]    r_out_pos;
    logic [ive_pkg::LEN_W-1:0]    r_out_len;

    logic                         w_finish;
    logic [ive_pkg::STATUS_W-1:0] w_status;
    logic [VW-1:0]                w_read;
    logic [ive_pkg::POS_W-1:0]    w_pos;
    logic [ive_pkg::LEN_W-1:0]    w_len;
    logic                         w_slot_free;
    logic                         w_in_fire;
    logic                         w_div_start;

    logic [CMPW+ive_pkg::IDX_W-1:0] w_idx_wide;
    logic [CMPW+CW-1:0]             w_cnt_wide;
    logic [CMPW-1:0]                w_idx;
    logic [CMPW-1:0]                w_cnt;
    logic                           w_idx_lt_cnt;
    logic                           w_idx_le_cnt;
    logic                           w_full;
    logic                           w_empty;

    logic [DW+VW-1:0]   w_val_wide;
    logic [DW-1:0]      w_val_word;
    logic [DW-1:0]      w_sel_word;
    logic [DW-1:0]      w_last_word;
    logic [DW-1:0]      w_wrap;
    logic [VW+DW-1:0]   w_sel_wide;

    logic [CAPACITY-1:0]          w_match;
    logic [CAPACITY-1:0]          w_hits;
    logic [CAPACITY-1:0]          w_first;
    logic [CMPW-1:0]              w_pos_full;
    logic [CMPW+ive_pkg::POS_W-1:0] w_pos_wide;
    logic [CW+ive_pkg::LEN_W-1:0]   w_len_wide;

    logic [DW-1:0]     w_word [CAPACITY];
    ive_pkg::t_cell_op w_op   [CAPACITY];

    logic          w_mod_done;
    logic [CW-1:0] w_mod_rem;

    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_slot_free = !r_out_valid || i_out_ready;

    // ---------------------------------------------------------------- decode
    assign w_idx_wide   = {{CMPW{1'b0}}, r_index};
    assign w_cnt_wide   = {{CMPW{1'b0}}, r_count};
    assign w_idx        = w_idx_wide[CMPW-1:0];
    assign w_cnt        = w_cnt_wide[CMPW-1:0];
    assign w_idx_lt_cnt = (w_idx < w_cnt);
    assign w_idx_le_cnt = (w_idx <= w_cnt);
    assign w_full       = (r_count == CW'(CAPACITY));
    assign w_empty      = (r_count == '0);

    assign w_val_wide = {{DW{1'b0}}, r_value};
    assign w_val_word = w_val_wide[DW-1:0];

    // word at the index, last word and hit flags by and-or over the cells
    always_comb begin
        w_sel_word  = '0;
        w_last_word = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_idx == CMPW'(i)) begin
                w_sel_word = w_sel_word | w_word[i];
            end
            if (w_cnt == CMPW'(i + 1)) begin
                w_last_word = w_last_word | w_word[i];
            end
            w_hits[i] = w_match[i] && (CMPW'(i) < w_cnt);
        end
    end

    assign w_sel_wide = {{VW{1'b0}}, w_sel_word};
    assign w_wrap     = (r_state == S_ROT) ? w_last_word : w_word[0];

    // first hit isolated by the lowest set bit, then encoded
    assign w_first = w_hits & (~w_hits + 1'b1);
    always_comb begin
        w_pos_full = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_first[i]) begin
                w_pos_full = w_pos_full | CMPW'(i);
            end
        end
    end
    assign w_pos_wide = {{ive_pkg::POS_W{1'b0}}, w_pos_full};

    // ------------------------------------------------------------ cell ops
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_op[i] = ive_pkg::OP_HOLD;
            if (r_state == S_EXEC) begin
                case (r_command)
                    ive_pkg::CMD_WRITE: begin
                        if (w_idx_lt_cnt && (w_idx == CMPW'(i))) begin
                            w_op[i] = ive_pkg::OP_LOAD;
                        end
                    end
                    ive_pkg::CMD_APPEND: begin
                        if (!w_full && (w_cnt == CMPW'(i))) begin
                            w_op[i] = ive_pkg::OP_LOAD;
                        end
                    end
                    ive_pkg::CMD_INSERT: begin
                        if (w_idx_le_cnt && !w_full) begin
                            if (w_idx == CMPW'(i)) begin
                                w_op[i] = ive_pkg::OP_LOAD;
                            end else if ((CMPW'(i) > w_idx) && (CMPW'(i) <= w_cnt)) begin
                                w_op[i] = ive_pkg::OP_LEFT;
                            end
                        end
                    end
                    ive_pkg::CMD_DELETE: begin
                        if (!w_empty && w_idx_lt_cnt) begin
                            if ((CMPW'(i) >= w_idx) && (CMPW'(i + 1) < w_cnt)) begin
                                w_op[i] = ive_pkg::OP_RIGHT;
                            end else if (CMPW'(i + 1) == w_cnt) begin
                                w_op[i] = ive_pkg::OP_CLEAR;
                            end
                        end
                    end
                    ive_pkg::CMD_ROTL: begin
                        if (CMPW'(i + 1) < w_cnt) begin
                            w_op[i] = ive_pkg::OP_RIGHT;
                        end else if (CMPW'(i + 1) == w_cnt) begin
                            w_op[i] = ive_pkg::OP_WRAP;
                        end
                    end
                    default: begin
                        w_op[i] = ive_pkg::OP_HOLD;
                    end
                endcase
            end else if (r_state == S_ROT) begin
                // rotate right by one within the held words
                if (i == 0) begin
                    w_op[i] = ive_pkg::OP_WRAP;
                end else if (CMPW'(i) < w_cnt) begin
                    w_op[i] = ive_pkg::OP_LEFT;
                end
            end
        end
    end

    // ---------------------------------------------------------- cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DW-1:0] w_left;
        logic [DW-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_inner_l
            assign w_left = w_word[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner_r
            assign w_right = w_word[g+1];
        end

        ive_cell #(
            .DATA_WIDTH (DW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_op[g]),
            .i_load  (w_val_word),
            .i_left  (w_left),
            .i_right (w_right),
            .i_wrap  (w_wrap),
            .i_key   (w_val_word),
            .o_word  (w_word[g]),
            .o_match (w_match[g])
        );
    end

    ive_mod_unit #(
        .CAPACITY (CAPACITY)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_steps (r_steps),
        .i_count (r_count),
        .o_done  (w_mod_done),
        .o_rem   (w_mod_rem)
    );

    // ------------------------------------------------------------ control
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        w_finish    = 1'b0;
        w_status    = ive_pkg::ST_OK;
        w_read      = '0;
        w_pos       = '0;
        w_div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                w_finish = 1'b1;
                case (r_command)
                    ive_pkg::CMD_READ: begin
                        if (w_idx_lt_cnt) begin
                            w_read = w_sel_wide[VW-1:0];
                        end else begin
                            w_status = ive_pkg::ST_RANGE;
                        end
                    end
                    ive_pkg::CMD_WRITE: begin
                        if (!w_idx_lt_cnt) begin
                            w_status = ive_pkg::ST_RANGE;
                        end
                    end
                    ive_pkg::CMD_FIND: begin
                        w_finish = 1'b0;
                        n_state  = S_FIND;
                    end
                    ive_pkg::CMD_APPEND: begin
                        if (w_full) begin
                            w_status = ive_pkg::ST_FULL;
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                    end
                    ive_pkg::CMD_INSERT: begin
                        if (!w_idx_le_cnt) begin
                            w_status = ive_pkg::ST_RANGE;
                        end else if (w_full) begin
                            w_status = ive_pkg::ST_FULL;
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                    end
                    ive_pkg::CMD_DELETE: begin
                        if (w_empty) begin
                            w_status = ive_pkg::ST_EMPTY;
                        end else if (!w_idx_lt_cnt) begin
                            w_status = ive_pkg::ST_RANGE;
                        end else begin
                            w_read  = w_sel_wide[VW-1:0];
                            n_count = r_count - 1'b1;
                        end
                    end
                    ive_pkg::CMD_ROTL: begin
                        w_status = ive_pkg::ST_OK;
                    end
                    ive_pkg::CMD_ROTR: begin
                        if (!w_empty) begin
                            w_finish    = 1'b0;
                            w_div_start = 1'b1;
                            n_state     = S_DIV;
                        end
                    end
                    default: begin
                        w_status = ive_pkg::ST_OK;
                    end
                endcase
            end
            S_FIND: begin
                w_finish = 1'b1;
                if (|w_hits) begin
                    w_pos = w_pos_wide[ive_pkg::POS_W-1:0];
                end else begin
                    w_status = ive_pkg::ST_MISS;
                end
            end
            S_DIV: begin
                if (w_mod_done) begin
                    if (w_mod_rem == '0) begin
                        w_finish = 1'b1;
                    end else begin
                        n_state = S_ROT;
                    end
                end
            end
            S_ROT: begin
                if (r_rot == CW'(1)) begin
                    w_finish = 1'b1;
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_finish) begin
            n_state = w_slot_free ? S_IDLE : S_DONE;
        end
    end

    assign w_len_wide = {{ive_pkg::LEN_W{1'b0}}, n_count};
    assign w_len      = w_len_wide[ive_pkg::LEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if ((w_finish || (r_state == S_DONE)) && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_command <= i_command;
            r_index   <= i_index;
            r_value   <= i_value;
            r_steps   <= i_steps;
        end
        if ((r_state == S_DIV) && w_mod_done) begin
            r_rot <= w_mod_rem;
        end else if (r_state == S_ROT) begin
            r_rot <= r_rot - 1'b1;
        end
        if (w_finish) begin
            r_res_status <= w_status;
            r_res_read   <= w_read;
            r_res_pos    <= w_pos;
            r_res_len    <= w_len;
        end
        if (w_finish && w_slot_free) begin
            r_out_status <= w_status;
            r_out_read   <= w_read;
            r_out_pos    <= w_pos;
            r_out_len    <= w_len;
        end else if ((r_state == S_DONE) && w_slot_free) begin
            r_out_status <= r_res_status;
            r_out_read   <= r_res_read;
            r_out_pos    <= r_res_pos;
            r_out_len    <= r_res_len;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_read_value = r_out_read;
    assign o_position   = r_out_pos;
    assign o_length     = r_out_len;

    // ---------------------------------------------------------- assertions
    `IVE_ASSERT_NOW(a_count_cap, 1'b1, r_count <= CW'(CAPACITY), "count above capacity")
    `IVE_ASSERT_NEXT(a_accept_exec, w_in_fire, r_state == S_EXEC, "accepted item not executed")
    `IVE_ASSERT_NOW(a_done_slot, r_state == S_DONE, r_out_valid, "parked result with free slot")
    `IVE_ASSERT_NEXT(a_count_step, 1'b1, (r_count == $past(r_count)) || (r_count == $past(r_count) + 1'b1) || (r_count + 1'b1 == $past(r_count)), "count moved by more than one")

endmodule
